// ===== design/lep_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Link echo pattern checker package
// Shared constants, item and result types, and the pattern function.
// ----------------------------------------------------------------------------
package lep_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [31:0] PAT_MULT   = 32'h9E37_79B1;
  localparam logic [31:0] SEND_BASE  = 32'hBE7D_0000;
  localparam logic [15:0] CTRL_ENTER = 16'hBE7C;
  localparam logic [15:0] CTRL_LEAVE = 16'h0000;
  localparam logic [15:0] TAG_RESET  = 16'h600D;
  localparam logic [15:0] HALF_MAX   = 16'hFFFF;

  // Configuration register indexes.
  localparam logic [0:0] REG_ECHO_EN = 1'b0;
  localparam logic [0:0] REG_TAG     = 1'b1;

  typedef struct packed {
    logic [31:0] reply_word;
    logic        first_of_run;
    logic        last_of_run;
  } lep_item_t;

  typedef struct packed {
    logic [31:0] next_send_word;
    logic        word_bad;
    logic [15:0] bad_total;
    logic        run_end;
  } lep_result_t;

  // Only the low 16 bits of the product survive, so a 16 by 32 multiply is enough.
  function automatic logic [15:0] pattern_of(input logic [15:0] idx);
    logic [47:0] prod;
    logic [15:0] p;
    prod = {32'd0, idx} * {16'd0, PAT_MULT};
    p = prod[15:0];
    if (p == CTRL_ENTER) p = p ^ 16'd1;
    if (p == CTRL_LEAVE) p = p ^ 16'd1;
    return p;
  endfunction

endpackage
`default_nettype wire

// ===== design/lep_check_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Link echo check core
// Holds the exchange state, checks one reply per advance and forms its result.
// ----------------------------------------------------------------------------
module lep_check_core
  import lep_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        advance,
  input  wire lep_item_t   item,
  input  wire logic        echo_en,
  input  wire logic [15:0] tag_value,
  output lep_result_t      result
);

  localparam logic [COUNT_BITS-1:0] TALLY_MAX = {COUNT_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] TALLY_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

  logic [15:0]           idx_r, idx_nxt;
  logic [15:0]           cur_pat_r, cur_pat_nxt;
  logic [15:0]           prev_pat_r;
  logic                  expect_r;
  logic [COUNT_BITS-1:0] tally_r, tally_nxt;

  logic [15:0]           idx;
  logic [15:0]           sent;
  logic                  expect_ok;
  logic [COUNT_BITS-1:0] tally;
  logic                  tag_bad;
  logic                  echo_bad;
  logic                  bad;
  logic [15:0]           shown;

  // The pattern of the current index is kept registered, so only the next
  // index needs a multiply in this cycle.
  always_comb begin
    idx       = item.first_of_run ? 16'd0 : idx_r;
    sent      = item.first_of_run ? pattern_of(16'd0) : cur_pat_r;
    expect_ok = item.first_of_run ? 1'b0 : expect_r;
    tally     = item.first_of_run ? '0 : tally_r;

    tag_bad  = item.reply_word[31:16] != tag_value;
    echo_bad = !tag_bad && echo_en && expect_ok && (item.reply_word[15:0] != prev_pat_r);
    bad      = tag_bad || echo_bad;

    tally_nxt   = (bad && (tally != TALLY_MAX)) ? tally + TALLY_ONE : tally;
    idx_nxt     = idx + 16'd1;
    cur_pat_nxt = pattern_of(idx_nxt);
  end

  generate
    if (COUNT_BITS > 16) begin : g_wide
      assign shown = (|tally_nxt[COUNT_BITS-1:16]) ? HALF_MAX : tally_nxt[15:0];
    end else begin : g_narrow
      assign shown = 16'(tally_nxt);
    end
  endgenerate

  always_comb begin
    result.next_send_word = SEND_BASE | {16'd0, cur_pat_nxt};
    result.word_bad       = bad;
    result.bad_total      = shown;
    result.run_end        = item.last_of_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r      <= '0;
      cur_pat_r  <= pattern_of(16'd0);
      prev_pat_r <= '0;
      expect_r   <= 1'b0;
      tally_r    <= '0;
    end else if (advance) begin
      idx_r      <= idx_nxt;
      cur_pat_r  <= cur_pat_nxt;
      prev_pat_r <= sent;
      expect_r   <= 1'b1;
      tally_r    <= tally_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/link_echo_pattern_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Link echo pattern checker
// Checks link test replies against the tag and the lagged echo pattern, and
// gives the next word to send with a saturating count of bad replies.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  in_      input      tdata: reply_word; tuser: first_of_run; tlast: last_of_run
//  out_     output     tdata: next_send_word, word_bad, bad_total; tlast: run_end
//  cfg_     input      cfg_index selects a register, cfg_data is written to it
//
// One transaction is accepted per cycle while the output is not stalled; each result
// passes through the input register, then the result register.
// The exchange state is updated as an item moves into the result register, so
// the combinational check and pattern multiply set the throughput.
// A stalled output holds its result while the input register still takes one
// more transaction. Reset is synchronous.
// ----------------------------------------------------------------------------
module link_echo_pattern_checker
  import lep_pkg::*;
#(
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] reply_word
  input  wire logic        in_tuser,   // [0] first_of_run
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [31:0] next_send_word, [32] word_bad,
                                       // [48:33] bad_total, [55:49] zero
  output logic             out_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic        in_valid_r;
  lep_item_t   in_item_r;
  logic        out_valid_r;
  lep_result_t out_res_r;
  lep_result_t res;
  logic        advance;
  logic        echo_en_r;
  logic [15:0] tag_r;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_en_r <= 1'b0;
      tag_r     <= TAG_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ECHO_EN: echo_en_r <= cfg_data[0];
        REG_TAG:     tag_r     <= cfg_data;
        default:     ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r.reply_word   <= in_tdata;
      in_item_r.first_of_run <= in_tuser;
      in_item_r.last_of_run  <= in_tlast;
    end
  end

  lep_check_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (in_item_r),
    .echo_en  (echo_en_r),
    .tag_value(tag_r),
    .result   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_res_r.bad_total, out_res_r.word_bad,
                       out_res_r.next_send_word};
  assign out_tlast  = out_res_r.run_end;

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Link echo pattern checker testbench
// Drives reply words into the checker through its stream input and compares
// every result with a local model of the tag check, the lagged echo check,
// the pattern sequence and the saturating bad-reply tally.
// ----------------------------------------------------------------------------
module tb;
  import lep_pkg::*;

  localparam int unsigned TALLY_BITS = 16;
  localparam longint unsigned TALLY_MAX = (64'd1 << TALLY_BITS) - 64'd1;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_ITEMS = 200;
  localparam int unsigned BAD_RUN_ITEMS = 300;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;
  logic        out_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  // Local copy of the checker's registers and exchange state.
  logic            echo_en_m;
  logic [15:0]     tag_m;
  logic [15:0]     idx_m;
  logic [15:0]     prev_pat_m;
  logic            valid_m;
  longint unsigned tally_m;

  lep_result_t verdicts_q[$];

  bit          idle_on;
  int unsigned replies_sent;
  int unsigned results_checked;
  int unsigned bad_flags;
  int unsigned reg_writes;
  int unsigned fail_count;
  int unsigned cycle_count;

  link_echo_pattern_checker #(
    .COUNT_BITS(TALLY_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] link_pattern(input logic [15:0] n);
    logic [31:0] prod;
    prod = {16'd0, n} * PAT_MULT;
    if (prod[15:0] == CTRL_ENTER) prod[0] = ~prod[0];
    if (prod[15:0] == CTRL_LEAVE) prod[0] = ~prod[0];
    return prod[15:0];
  endfunction

  // Advances the model by one reply and returns the result it should produce.
  function automatic lep_result_t check_reply(input lep_item_t it);
    lep_result_t r;
    logic [15:0] sent;
    logic        bad;
    if (it.first_of_run) begin
      idx_m = '0;
      tally_m = 0;
      valid_m = 1'b0;
    end
    sent = link_pattern(idx_m);
    bad = 1'b0;
    if (it.reply_word[31:16] != tag_m) begin
      bad = 1'b1;
      valid_m = 1'b0;
    end else if (echo_en_m && valid_m && it.reply_word[15:0] != prev_pat_m) begin
      bad = 1'b1;
    end
    if (bad && tally_m < TALLY_MAX) tally_m = tally_m + 1;
    prev_pat_m = sent;
    valid_m = 1'b1;
    idx_m = idx_m + 16'd1;
    r.next_send_word = SEND_BASE | {16'd0, link_pattern(idx_m)};
    r.word_bad = bad;
    r.bad_total = (tally_m > 64'hFFFF) ? HALF_MAX : tally_m[15:0];
    r.run_end = it.last_of_run;
    return r;
  endfunction

  // The reply a well-behaved far end would give to the current exchange.
  function automatic logic [31:0] good_echo();
    return {tag_m, prev_pat_m};
  endfunction

  function automatic logic [31:0] make_reply();
    logic [31:0] w;
    logic [31:0] rnd;
    rnd = $urandom;
    case ($urandom_range(0, 9))
      0: w = rnd;
      1: w = {tag_m ^ (16'd1 << $urandom_range(0, 15)), prev_pat_m};
      2: w = {rnd[31:16], prev_pat_m};
      3: w = {tag_m, prev_pat_m ^ (16'd1 << $urandom_range(0, 15))};
      4: w = {tag_m, rnd[15:0]};
      default: w = good_echo();
    endcase
    return w;
  endfunction

  task automatic send_reply(input logic [31:0] word, input logic first, input logic last);
    lep_item_t it;
    int unsigned gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    it.reply_word = word;
    it.first_of_run = first;
    it.last_of_run = last;
    verdicts_q.push_back(check_reply(it));
    replies_sent++;
  endtask

  // Stops the input and waits until every outstanding result has come out.
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (verdicts_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_ECHO_EN) echo_en_m = data[0];
    else tag_m = data;
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Reset values, a reply with no run mark straight after reset, and raw extremes.
  task automatic test_reset_state();
    send_reply({TAG_RESET, 16'h1234}, 1'b0, 1'b0);
    send_reply(good_echo(), 1'b0, 1'b0);
    send_reply(32'h0000_0000, 1'b0, 1'b0);
    send_reply(32'hFFFF_FFFF, 1'b0, 1'b1);
  endtask

  task automatic test_echo_directed();
    write_reg(REG_ECHO_EN, 16'h0001);
    write_reg(REG_TAG, 16'hFFFF);
    send_reply({16'hFFFF, 16'h0000}, 1'b1, 1'b0);
    send_reply(good_echo(), 1'b0, 1'b0);
    send_reply(good_echo() ^ 32'h0000_8000, 1'b0, 1'b0);
    // A tag mismatch skips the echo check but still arms the next one.
    send_reply({16'h7FFF, prev_pat_m}, 1'b0, 1'b0);
    send_reply(good_echo(), 1'b0, 1'b0);
    send_reply(good_echo() ^ 32'h0000_0001, 1'b0, 1'b0);
    send_reply(32'h0000_0000, 1'b1, 1'b1);
    // Only bit 0 of the enable write counts.
    write_reg(REG_ECHO_EN, 16'hFFFE);
    write_reg(REG_TAG, 16'h0000);
    send_reply(32'h0000_FFFF, 1'b1, 1'b0);
    send_reply(32'h0000_0000, 1'b0, 1'b0);
    send_reply(32'h8000_0000, 1'b0, 1'b1);
  endtask

  task automatic run_random_phase(input int unsigned n_items, input bit pause_midway);
    int unsigned done;
    int unsigned run_len;
    logic        first;
    logic        last;
    done = 0;
    while (done < n_items) begin
      run_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 40);
      for (int unsigned k = 0; k < run_len; k++) begin
        first = (k == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
        last = (k == run_len - 1) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
        send_reply(make_reply(), first, last);
        done++;
        if (pause_midway && done == n_items / 2) wait_drained();
      end
    end
  endtask

  task automatic test_random_settings();
    logic [15:0] tag_pick;
    for (int unsigned ph = 0; ph < 7; ph++) begin
      case (ph)
        0: tag_pick = 16'h0000;
        1: tag_pick = 16'hFFFF;
        default: tag_pick = $urandom_range(0, 65535);
      endcase
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_TAG, tag_pick);
        write_reg(REG_ECHO_EN, (ph == 1) ? 16'h0000 : 16'($urandom_range(0, 65535)));
      end else begin
        write_reg(REG_ECHO_EN, (ph == 0) ? 16'h0001 : 16'($urandom_range(0, 65535)));
        write_reg(REG_TAG, tag_pick);
      end
      run_random_phase(PHASE_ITEMS, ph == 2);
    end
  endtask

  // One long run of mostly bad replies, back to back, with a good echo now and then.
  task automatic test_bad_run();
    write_reg(REG_ECHO_EN, 16'h0001);
    write_reg(REG_TAG, 16'($urandom_range(0, 65535)));
    for (int unsigned k = 0; k < BAD_RUN_ITEMS; k++) begin
      if (k % 97 == 5) send_reply(good_echo(), 1'b0, 1'b0);
      else send_reply({~tag_m, 16'($urandom)}, k == 0, k == BAD_RUN_ITEMS - 1);
    end
  endtask

  task automatic test_quiet_tail();
    write_reg(REG_ECHO_EN, 16'h0001);
    write_reg(REG_TAG, 16'($urandom_range(0, 65535)));
    run_random_phase(PHASE_ITEMS, 1'b0);
  endtask

  always @(posedge clk) begin : result_check
    lep_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (verdicts_q.size() == 0) begin
        $error("result transaction with no reply outstanding: tdata %h", out_tdata);
        fail_count++;
      end else begin
        want = verdicts_q.pop_front();
        results_checked++;
        if (out_tdata[32]) bad_flags++;
        if (out_tdata[31:0] != want.next_send_word) begin
          $error("next_send_word: expected %h, got %h", want.next_send_word, out_tdata[31:0]);
          fail_count++;
        end
        if (out_tdata[32] != want.word_bad) begin
          $error("word_bad: expected %0d, got %0d", want.word_bad, out_tdata[32]);
          fail_count++;
        end
        if (out_tdata[48:33] != want.bad_total) begin
          $error("bad_total: expected %0d, got %0d", want.bad_total, out_tdata[48:33]);
          fail_count++;
        end
        if (out_tlast != want.run_end) begin
          $error("run_end: expected %0d, got %0d", want.run_end, out_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("link_echo_pattern_checker: mismatch");
      $finish;
    end
  end

  // Receiver stalls come in bursts, with occasional long quiet windows.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 15) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_ECHO_EN;
    cfg_data = '0;
    idle_on = 1'b1;
    echo_en_m = 1'b0;
    tag_m = TAG_RESET;
    idx_m = '0;
    prev_pat_m = '0;
    valid_m = 1'b0;
    tally_m = 0;
    replies_sent = 0;
    results_checked = 0;
    bad_flags = 0;
    reg_writes = 0;
    fail_count = 0;
    cycle_count = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_echo_directed();
    test_random_settings();
    idle_on = 1'b0;
    test_bad_run();
    test_quiet_tail();

    wait_drained();
    repeat (10) @(posedge clk);
    if (verdicts_q.size() != 0) begin
      $error("%0d results never arrived", verdicts_q.size());
      fail_count++;
    end
    $display("Run covered %0d replies and %0d results over %0d register writes, %0d flagged bad,",
             replies_sent, results_checked, reg_writes, bad_flags);
    $display("including tag and echo faults, run restarts, stalls and a long bad-reply run.");
    if (fail_count == 0) begin
      $display("link_echo_pattern_checker: match");
    end else begin
      $display("link_echo_pattern_checker: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lep_pkg.sv
design/lep_check_core.sv
design/link_echo_pattern_checker.sv
dv/tb.sv
